[rtl/core/tai_pkg.sv]
package tai_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Coefficients b and h are unsigned Q0.18 held in 19 bits so that 1.0 fits.
   localparam int               COEF_BITS     = 18;
   localparam int               COEF_W        = 19;
   localparam logic [COEF_W-1:0] COEF_ONE      = 19'h40000;
   localparam logic [COEF_W-1:0] DAMPING_RESET = 19'd54574;
   localparam logic [COEF_W-1:0] STEP_RESET    = 19'd2621;

   // Pi scaled by 2^60, truncated.
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   // Divisors of the nested sine series and their rounded-up base-two logarithms.
   localparam int TAYLOR_DIV [4] = '{72, 42, 20, 6};
   localparam int TAYLOR_LOG [4] = '{7, 6, 5, 3};

   // Sum of the Runge-Kutta weights 1, 2, 2, 1.
   localparam int RK_WEIGHT_SUM = 6;

   typedef enum logic [1:0] {
      REG_DAMPING = 2'd0,
      REG_STEP    = 2'd1,
      REG_METHOD  = 2'd2
   } csr_index_type;

   typedef enum logic {
      METHOD_RK4   = 1'b0,
      METHOD_EULER = 1'b1
   } method_type;

endpackage

[rtl/core/tai_channels.sv]
interface tai_req_if #(
   parameter int WORD_BITS = 24
) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] pos_x;
   logic signed [WORD_BITS-1:0] pos_y;
   logic signed [WORD_BITS-1:0] pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface tai_rsp_if #(
   parameter int WORD_BITS = 24
) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] next_x;
   logic signed [WORD_BITS-1:0] next_y;
   logic signed [WORD_BITS-1:0] next_z;
   logic                        saturated;

   modport source (output valid, next_x, next_y, next_z, saturated, input ready);
   modport sink   (input valid, next_x, next_y, next_z, saturated, output ready);
endinterface

[rtl/core/tai_deriv.sv]
module tai_deriv
   import tai_pkg::*;
#(
   parameter int FRAC_BITS = 18,
   parameter int DW        = 27,
   parameter int SB_W      = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] in_point [3],
   input  logic [SB_W-1:0]      in_side,
   input  logic [COEF_W-1:0]    damping,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_k [3],
   output logic [SB_W-1:0]      out_side
);

   localparam int L     = 14;
   localparam int F     = FRAC_BITS;
   localparam int SN    = DW + 1;
   localparam int RNW   = SN - F - 1;
   localparam int NW    = DW - F + 1;
   localparam int RAW_W = F + 5;
   localparam int RW    = F + 3;
   localparam int N2    = F + 2;

   localparam logic [63:0] ONE_U    = 64'd1 << F;
   localparam logic [63:0] PI_U     = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
   localparam logic [63:0] HALF_U   = (PI_Q60 + (64'd1 << (60 - F))) >> (61 - F);
   localparam logic [63:0] TWO_PI_U = PI_U << 1;
   localparam logic [63:0] RN_U     = (64'd1 << SN) / TWO_PI_U;

   localparam logic [RNW-1:0]          RN_C      = RNW'(RN_U);
   localparam logic signed [RAW_W-1:0] PI_R      = RAW_W'(PI_U);
   localparam logic signed [RAW_W-1:0] HALF_R    = RAW_W'(HALF_U);
   localparam logic signed [RAW_W-1:0] TWO_PI_R  = RAW_W'(TWO_PI_U);
   localparam logic signed [DW+1:0]    TWO_PI_D  = (DW+2)'(TWO_PI_U);
   localparam logic signed [RW-1:0]    ONE_S     = RW'(ONE_U);
   localparam logic [F:0]              ONE_T     = (F+1)'(ONE_U);

   // Reciprocals that make each series division exact for operands below 2^N2.
   localparam logic [63:0] TAY_M [4] = '{
      ((64'd1 << (N2 + TAYLOR_LOG[0])) + 64'(TAYLOR_DIV[0]) - 64'd1) / 64'(TAYLOR_DIV[0]),
      ((64'd1 << (N2 + TAYLOR_LOG[1])) + 64'(TAYLOR_DIV[1]) - 64'd1) / 64'(TAYLOR_DIV[1]),
      ((64'd1 << (N2 + TAYLOR_LOG[2])) + 64'(TAYLOR_DIV[2]) - 64'd1) / 64'(TAYLOR_DIV[2]),
      ((64'd1 << (N2 + TAYLOR_LOG[3])) + 64'(TAYLOR_DIV[3]) - 64'd1) / 64'(TAYLOR_DIV[3])
   };

   logic [L-1:0]            valid_ff;
   logic [SB_W-1:0]         side_ff  [L];
   logic signed [DW-1:0]    damp_ff  [L-1][3];
   logic signed [DW-1:0]    a_ff     [3];
   logic signed [NW-1:0]    n_ff     [3];
   logic signed [RAW_W-1:0] raw_ff   [3];
   logic signed [RW-1:0]    rp_ff    [10][3];
   logic [N2-1:0]           r2p_ff   [7][3];
   logic [N2-1:0]           prod_ff  [4][3];
   logic [F:0]              t_ff     [4][3];
   logic signed [RW-1:0]    sin_ff   [3];
   logic signed [DW-1:0]    k_ff     [3];

   logic signed [DW-1:0]    a_in     [3];
   logic signed [NW-1:0]    n_in     [3];
   logic signed [DW-1:0]    damp_in  [3];
   logic signed [RAW_W-1:0] raw_in   [3];
   logic signed [RW-1:0]    rf_in    [3];
   logic [N2-1:0]           r2_in    [3];
   logic [N2-1:0]           prod_in  [4][3];
   logic [F:0]              t_in     [4][3];
   logic signed [RW-1:0]    sin_in   [3];
   logic signed [DW-1:0]    k_in     [3];

   always_comb begin
      logic signed [DW:0]          ap;
      logic signed [DW+RNW+1:0]    np;
      logic signed [DW+COEF_W:0]   dp;
      logic signed [DW+1:0]        rt;
      logic signed [RAW_W-1:0]     rc;
      logic signed [2*RW-1:0]      rr;
      logic [F:0]                  tsrc;
      logic [F+N2:0]               tp;
      logic [2*N2:0]               qp;
      logic signed [RW+F+1:0]      sp;
      logic signed [RW-1:0]        sc;
      for (int i = 0; i < 3; i++) begin
         // Lane i takes the sine of the next coordinate and damps its own.
         a_in[i] = in_point[(i + 1) % 3];
         ap = (DW+1)'(in_point[(i + 1) % 3]) + $signed((DW+1)'(PI_U));
         np = ap * $signed({1'b0, RN_C});
         n_in[i] = NW'(np >>> SN);
         dp = in_point[i] * $signed({1'b0, damping});
         damp_in[i] = DW'(dp >>> COEF_BITS);

         rt = (DW+2)'(a_ff[i]) - (DW+2)'(n_ff[i]) * TWO_PI_D;
         raw_in[i] = RAW_W'(rt);

         // The period estimate may be one off in either direction; one step fixes it.
         rc = raw_ff[i];
         if (rc >= PI_R) begin
            rc = rc - TWO_PI_R;
         end else if (rc < -PI_R) begin
            rc = rc + TWO_PI_R;
         end
         if (rc > HALF_R) begin
            rc = PI_R - rc;
         end else if (rc < -HALF_R) begin
            rc = -PI_R - rc;
         end
         rf_in[i] = RW'(rc);

         rr = rp_ff[0][i] * rp_ff[0][i];
         r2_in[i] = N2'(rr >>> F);

         for (int j = 0; j < 4; j++) begin
            tsrc = (j == 0) ? ONE_T : t_ff[(j == 0) ? 0 : j - 1][i];
            tp = tsrc * r2p_ff[2 * j][i];
            prod_in[j][i] = N2'(tp >> F);
            qp = prod_ff[j][i] * (N2+1)'(TAY_M[j]);
            t_in[j][i] = ONE_T - (F+1)'(qp >> (N2 + TAYLOR_LOG[j]));
         end

         sp = rp_ff[9][i] * $signed({1'b0, t_ff[3][i]});
         sin_in[i] = RW'(sp >>> F);

         sc = sin_ff[i];
         if (sc > ONE_S) begin
            sc = ONE_S;
         end else if (sc < -ONE_S) begin
            sc = -ONE_S;
         end
         k_in[i] = DW'(sc) - damp_ff[L-2][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[L-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < L; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int i = 0; i < 3; i++) begin
            a_ff[i]       <= a_in[i];
            n_ff[i]       <= n_in[i];
            raw_ff[i]     <= raw_in[i];
            damp_ff[0][i] <= damp_in[i];
            for (int s = 1; s < L - 1; s++) begin
               damp_ff[s][i] <= damp_ff[s-1][i];
            end
            rp_ff[0][i] <= rf_in[i];
            for (int s = 1; s < 10; s++) begin
               rp_ff[s][i] <= rp_ff[s-1][i];
            end
            r2p_ff[0][i] <= r2_in[i];
            for (int s = 1; s < 7; s++) begin
               r2p_ff[s][i] <= r2p_ff[s-1][i];
            end
            for (int j = 0; j < 4; j++) begin
               prod_ff[j][i] <= prod_in[j][i];
               t_ff[j][i]    <= t_in[j][i];
            end
            sin_ff[i] <= sin_in[i];
            k_ff[i]   <= k_in[i];
         end
      end
   end

   assign out_valid = valid_ff[L-1];
   assign out_side  = side_ff[L-1];
   assign out_k     = k_ff;

endmodule

[rtl/core/thomas_attractor_integrator_step.sv]
// Channel   Direction  Handshake      Payload
// req_chan  in         valid/ready    pos_x, pos_y, pos_z
// rsp_chan  out        valid/ready    next_x, next_y, next_z, saturated
// APB       in         psel/penable   damping_coef, step_size, method
//
// One point enters per cycle unless the pipeline holds. Each result passes
// through four derivative pipelines of 14 stages each, three stage-point
// registers, three final stages and the output register. Reset clears all
// valid bits and restores the register defaults. When a result waits on
// rsp_chan the whole pipeline holds, and req_chan is not ready in that cycle.
module thomas_attractor_integrator_step
   import tai_pkg::*;
#(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   tai_req_if.sink               req_chan,
   tai_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int W     = WORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int DW    = ((W > F) ? W : F + 1) + 3;
   localparam int SW    = DW + 3;
   localparam int MW    = SW + 1;
   localparam int R6W   = MW - 2;
   localparam int X_OFF = 0;
   localparam int K_OFF = 3 * W;
   localparam int A_OFF = 3 * W + 3 * DW;
   localparam int SB_W  = 3 * W + 3 * DW + 3 * SW;

   localparam logic [63:0]         R6_U = (64'd1 << MW) / 64'(RK_WEIGHT_SUM);
   localparam logic [R6W-1:0]      R6_C = R6W'(R6_U);
   localparam logic signed [MW:0]  MAXV = (MW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [MW:0]  MINV = -MAXV - (MW+1)'(1);

   // Configuration registers.
   logic [COEF_W-1:0] damping_ff;
   logic [COEF_W-1:0] step_ff;
   method_type        method_ff;
   logic [COEF_W-1:0] damping_eff;
   logic [COEF_W-1:0] step_eff;
   logic              csr_write;

   // Pipeline advance: everything moves unless a result is waiting.
   logic adv;

   logic [3:0]           d_in_valid;
   logic signed [DW-1:0] d_in_point  [4][3];
   logic [SB_W-1:0]      d_in_side   [4];
   logic [3:0]           d_out_valid;
   logic signed [DW-1:0] d_out_k     [4][3];
   logic [SB_W-1:0]      d_out_side  [4];

   logic [2:0]           sp_valid_ff;
   logic signed [DW-1:0] sp_point_ff [3][3];
   logic [SB_W-1:0]      sp_side_ff  [3];
   logic signed [DW-1:0] sp_point_in [3][3];
   logic [SB_W-1:0]      sp_side_in  [3];

   logic                 f1_valid_ff;
   logic signed [W-1:0]  f1_x_ff  [3];
   logic signed [MW-1:0] f1_m_ff  [3];
   logic signed [MW-1:0] f1_m_in  [3];
   logic                 f2_valid_ff;
   logic signed [W-1:0]  f2_x_ff  [3];
   logic signed [MW-1:0] f2_m_ff  [3];
   logic signed [MW-1:0] f2_q_ff  [3];
   logic signed [MW-1:0] f2_q_in  [3];
   logic                 f3_valid_ff;
   logic signed [W-1:0]  f3_x_ff  [3];
   logic signed [MW-1:0] f3_inc_ff [3];
   logic signed [MW-1:0] f3_inc_in [3];

   logic                 rsp_valid_ff;
   logic signed [W-1:0]  next_ff  [3];
   logic signed [W-1:0]  next_in  [3];
   logic                 sat_ff;
   logic                 sat_in;

   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= DAMPING_RESET;
         step_ff    <= STEP_RESET;
         method_ff  <= METHOD_RK4;
      end else if (csr_write) begin
         unique case (csr_index_type'(paddr[3:2]))
            REG_DAMPING: damping_ff <= pwdata[COEF_W-1:0];
            REG_STEP:    step_ff    <= pwdata[COEF_W-1:0];
            REG_METHOD:  method_ff  <= method_type'(pwdata[0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[3:2]))
         REG_DAMPING: prdata = CSR_DATA_W'(damping_ff);
         REG_STEP:    prdata = CSR_DATA_W'(step_ff);
         REG_METHOD:  prdata = CSR_DATA_W'(method_ff);
         default:     prdata = '0;
      endcase
   end

   // Coefficients above one are used as one.
   assign damping_eff = (damping_ff > COEF_ONE) ? COEF_ONE : damping_ff;
   assign step_eff    = (step_ff > COEF_ONE) ? COEF_ONE : step_ff;

   assign adv            = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = adv;

   // First derivative stage takes the point straight from the request.
   always_comb begin
      d_in_valid[0] = req_chan.valid;
      d_in_point[0][0] = DW'(req_chan.pos_x);
      d_in_point[0][1] = DW'(req_chan.pos_y);
      d_in_point[0][2] = DW'(req_chan.pos_z);
      d_in_side[0] = '0;
      d_in_side[0][X_OFF + 0*W +: W] = req_chan.pos_x;
      d_in_side[0][X_OFF + 1*W +: W] = req_chan.pos_y;
      d_in_side[0][X_OFF + 2*W +: W] = req_chan.pos_z;
      for (int g = 1; g < 4; g++) begin
         d_in_valid[g] = sp_valid_ff[g-1];
         d_in_point[g] = sp_point_ff[g-1];
         d_in_side[g]  = sp_side_ff[g-1];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_deriv
      tai_deriv #(
         .FRAC_BITS (F),
         .DW        (DW),
         .SB_W      (SB_W)
      ) u_deriv (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (d_in_valid[g]),
         .in_point  (d_in_point[g]),
         .in_side   (d_in_side[g]),
         .damping   (damping_eff),
         .out_valid (d_out_valid[g]),
         .out_k     (d_out_k[g]),
         .out_side  (d_out_side[g])
      );
   end

   // Stage points for the next derivative and the weighted slope sum.
   always_comb begin
      logic signed [W-1:0]        xv;
      logic signed [DW-1:0]       kv;
      logic signed [DW+COEF_W:0]  kh;
      logic signed [SW-1:0]       acc;
      for (int g = 0; g < 3; g++) begin
         sp_side_in[g] = d_out_side[g];
         for (int i = 0; i < 3; i++) begin
            xv = d_out_side[g][X_OFF + i*W +: W];
            kv = d_out_k[g][i];
            kh = kv * $signed({1'b0, step_eff});
            if (g == 2) begin
               sp_point_in[g][i] = DW'((DW+COEF_W+1)'(xv) + (kh >>> COEF_BITS));
            end else begin
               sp_point_in[g][i] = DW'((DW+COEF_W+1)'(xv) + (kh >>> (COEF_BITS + 1)));
            end
            acc = d_out_side[g][A_OFF + i*SW +: SW];
            if (g == 0) begin
               sp_side_in[g][K_OFF + i*DW +: DW] = kv;
               acc = SW'(kv);
            end else begin
               acc = acc + (SW'(kv) <<< 1);
            end
            sp_side_in[g][A_OFF + i*SW +: SW] = acc;
         end
      end
   end

   // Increment: weighted sum times h over 6, or the first slope times h.
   always_comb begin
      logic signed [DW-1:0]       k1v;
      logic signed [SW-1:0]       acc;
      logic signed [SW-1:0]       op;
      logic signed [SW+COEF_W:0]  mh;
      logic signed [2*MW-2:0]     qp;
      logic signed [MW+2:0]       rem;
      logic signed [MW-1:0]       q;
      logic signed [MW:0]         v;
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         k1v = d_out_side[3][K_OFF + i*DW +: DW];
         acc = d_out_side[3][A_OFF + i*SW +: SW];
         if (method_ff == METHOD_EULER) begin
            op = SW'(k1v);
         end else begin
            op = acc + SW'(d_out_k[3][i]);
         end
         mh = op * $signed({1'b0, step_eff});
         f1_m_in[i] = MW'(mh >>> COEF_BITS);

         qp = f1_m_ff[i] * $signed({1'b0, R6_C});
         f2_q_in[i] = MW'(qp >>> MW);

         // The reciprocal estimate is at most one off; the remainder says which way.
         q = f2_q_ff[i];
         rem = (MW+3)'(f2_m_ff[i]) - (MW+3)'(f2_q_ff[i]) * (MW+3)'(RK_WEIGHT_SUM);
         if (rem < 0) begin
            q = q - MW'(1);
         end else if (rem >= (MW+3)'(RK_WEIGHT_SUM)) begin
            q = q + MW'(1);
         end
         f3_inc_in[i] = (method_ff == METHOD_EULER) ? f2_m_ff[i] : q;

         v = (MW+1)'(f3_x_ff[i]) + (MW+1)'(f3_inc_ff[i]);
         if (v > MAXV) begin
            next_in[i] = W'(MAXV);
            sat_in = 1'b1;
         end else if (v < MINV) begin
            next_in[i] = W'(MINV);
            sat_in = 1'b1;
         end else begin
            next_in[i] = W'(v);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_valid_ff  <= '0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sp_valid_ff  <= d_out_valid[2:0];
         f1_valid_ff  <= d_out_valid[3];
         f2_valid_ff  <= f1_valid_ff;
         f3_valid_ff  <= f2_valid_ff;
         rsp_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_point_ff <= sp_point_in;
         sp_side_ff  <= sp_side_in;
         for (int i = 0; i < 3; i++) begin
            f1_x_ff[i]   <= d_out_side[3][X_OFF + i*W +: W];
            f1_m_ff[i]   <= f1_m_in[i];
            f2_x_ff[i]   <= f1_x_ff[i];
            f2_m_ff[i]   <= f1_m_ff[i];
            f2_q_ff[i]   <= f2_q_in[i];
            f3_x_ff[i]   <= f2_x_ff[i];
            f3_inc_ff[i] <= f3_inc_in[i];
            next_ff[i]   <= next_in[i];
         end
         sat_ff <= sat_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.next_x    = next_ff[0];
   assign rsp_chan.next_y    = next_ff[1];
   assign rsp_chan.next_z    = next_ff[2];
   assign rsp_chan.saturated = sat_ff;

endmodule

[verif/thomas_attractor_integrator_step_test.sv]
module thomas_attractor_integrator_step_test;
   import tai_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD = 24;
   localparam int FRAC = 18;
   localparam int LATENCY = 63;
   localparam int IDLE_LIMIT = 20000;
   localparam longint ONE_Q = longint'(1) << FRAC;
   localparam longint MAX_Q = (longint'(1) << (WORD - 1)) - 1;
   localparam longint MIN_Q = -MAX_Q - 1;

   typedef struct packed {
      logic [WORD-1:0] x;
      logic [WORD-1:0] y;
      logic [WORD-1:0] z;
   } point_type;

   typedef struct packed {
      logic [WORD-1:0] x;
      logic [WORD-1:0] y;
      logic [WORD-1:0] z;
      logic            sat;
   } step_result_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tai_req_if #(.WORD_BITS(WORD)) req_chan ();
   tai_rsp_if #(.WORD_BITS(WORD)) rsp_chan ();

   thomas_attractor_integrator_step #(
      .WORD_BITS(WORD),
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Copy of the block's registers as the predictor sees them.
   logic [COEF_W-1:0] cfg_damping;
   logic [COEF_W-1:0] cfg_step;
   method_type        cfg_method;

   point_type       pending_points[$];
   step_result_type expected_points[$];
   int              fail_count;
   int              idle_cycles;
   bit              no_idle;
   bit              req_taken;
   int              send_gap;
   int              stall_left;
   int              hold_request;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) begin
         return n / d;
      end
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint qmul(longint a, longint c);
      return (a * c) >>> FRAC;
   endfunction

   function automatic longint sine_q(longint a);
      longint pi_q;
      longint half_q;
      longint n;
      longint r;
      longint r2;
      longint t;
      longint s;
      pi_q = longint'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
      half_q = longint'((PI_Q60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
      n = floor_div(a + pi_q, 2 * pi_q);
      r = a - n * 2 * pi_q;
      if (r > half_q) begin
         r = pi_q - r;
      end
      if (r < -half_q) begin
         r = -pi_q - r;
      end
      r2 = qmul(r, r);
      t = ONE_Q;
      for (int i = 0; i < 4; i++) begin
         t = ONE_Q - floor_div(qmul(t, r2), TAYLOR_DIV[i]);
      end
      s = qmul(r, t);
      if (s > ONE_Q) begin
         s = ONE_Q;
      end
      if (s < -ONE_Q) begin
         s = -ONE_Q;
      end
      return s;
   endfunction

   function automatic void slope(input longint p[3], input longint b, output longint k[3]);
      k[0] = sine_q(p[1]) - ((p[0] * b) >>> COEF_BITS);
      k[1] = sine_q(p[2]) - ((p[1] * b) >>> COEF_BITS);
      k[2] = sine_q(p[0]) - ((p[2] * b) >>> COEF_BITS);
   endfunction

   function automatic step_result_type thomas_next(point_type pt);
      longint          b;
      longint          h;
      longint          x[3];
      longint          p[3];
      longint          k1[3];
      longint          k2[3];
      longint          k3[3];
      longint          k4[3];
      longint          v[3];
      longint          inc;
      step_result_type res;
      b = longint'(cfg_damping);
      h = longint'(cfg_step);
      if (b > (longint'(1) << COEF_BITS)) begin
         b = longint'(1) << COEF_BITS;
      end
      if (h > (longint'(1) << COEF_BITS)) begin
         h = longint'(1) << COEF_BITS;
      end
      x[0] = longint'($signed(pt.x));
      x[1] = longint'($signed(pt.y));
      x[2] = longint'($signed(pt.z));
      slope(x, b, k1);
      if (cfg_method == METHOD_RK4) begin
         for (int i = 0; i < 3; i++) p[i] = x[i] + ((k1[i] * h) >>> (COEF_BITS + 1));
         slope(p, b, k2);
         for (int i = 0; i < 3; i++) p[i] = x[i] + ((k2[i] * h) >>> (COEF_BITS + 1));
         slope(p, b, k3);
         for (int i = 0; i < 3; i++) p[i] = x[i] + ((k3[i] * h) >>> COEF_BITS);
         slope(p, b, k4);
      end
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (cfg_method == METHOD_RK4) begin
            inc = floor_div((k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) * h,
                            RK_WEIGHT_SUM * (longint'(1) << COEF_BITS));
         end else begin
            inc = (k1[i] * h) >>> COEF_BITS;
         end
         v[i] = x[i] + inc;
         if (v[i] > MAX_Q) begin
            v[i] = MAX_Q;
            res.sat = 1'b1;
         end else if (v[i] < MIN_Q) begin
            v[i] = MIN_Q;
            res.sat = 1'b1;
         end
      end
      res.x = v[0][WORD-1:0];
      res.y = v[1][WORD-1:0];
      res.z = v[2][WORD-1:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 65) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Driver: a new point goes out after the previous transaction completes.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_chan.valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               point_type pt;
               pt = pending_points.pop_front();
               req_chan.pos_x <= pt.x;
               req_chan.pos_y <= pt.y;
               req_chan.pos_z <= pt.z;
               req_chan.valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         req_taken <= 1'b0;
      end
   end

   // Receiver back-pressure, including the occasional long hold-off.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_request != 0) begin
         stall_left <= hold_request;
         hold_request = 0;
         rsp_chan.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 149) == 0) begin
         stall_left <= $urandom_range(10, 40);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(0, 9) > 2);
      end
   end

   // Monitor: predict on input acceptance, check on output acceptance.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            point_type pt;
            pt.x = req_chan.pos_x;
            pt.y = req_chan.pos_y;
            pt.z = req_chan.pos_z;
            expected_points.push_back(thomas_next(pt));
            req_taken <= 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("unexpected result x=%h y=%h z=%h sat=%b", rsp_chan.next_x,
                           rsp_chan.next_y, rsp_chan.next_z, rsp_chan.saturated);
               end
            end else begin
               step_result_type exp_res;
               exp_res = expected_points.pop_front();
               if (rsp_chan.next_x !== exp_res.x || rsp_chan.next_y !== exp_res.y ||
                   rsp_chan.next_z !== exp_res.z || rsp_chan.saturated !== exp_res.sat) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display({"mismatch: expected x=%h y=%h z=%h sat=%b, ",
                               "got x=%h y=%h z=%h sat=%b"},
                              exp_res.x, exp_res.y, exp_res.z, exp_res.sat, rsp_chan.next_x,
                              rsp_chan.next_y, rsp_chan.next_z, rsp_chan.saturated);
                  end
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_DAMPING: cfg_damping = value[COEF_W-1:0];
         REG_STEP:    cfg_step = value[COEF_W-1:0];
         REG_METHOD:  cfg_method = method_type'(value[0]);
         default: ;
      endcase
   endtask

   // Writing past the last register must change nothing.
   task automatic csr_write_unmapped(logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'(12);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_points.size() > 0 || req_chan.valid || expected_points.size() > 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [WORD-1:0] rand_coord(bit wide);
      if (wide) begin
         return WORD'($urandom);
      end
      return WORD'($urandom_range(0, 1 << 22) - (1 << 21));
   endfunction

   task automatic queue_point(logic [WORD-1:0] x, logic [WORD-1:0] y, logic [WORD-1:0] z);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      pending_points.push_back(pt);
   endtask

   task automatic queue_random(int count);
      bit wide;
      for (int i = 0; i < count; i++) begin
         wide = ($urandom_range(0, 9) == 0);
         queue_point(rand_coord(wide), rand_coord(wide), rand_coord(wide));
      end
   endtask

   task automatic queue_directed();
      logic [WORD-1:0] vals[8];
      vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
               24'h0C90FE, 24'hF36F02, 24'h064880};
      for (int i = 0; i < 8; i++) begin
         queue_point(vals[i], vals[(i + 3) % 8], vals[(i + 5) % 8]);
      end
      queue_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      queue_point(24'h800000, 24'h800000, 24'h800000);
      queue_point(24'h555555, 24'hAAAAAA, 24'h333333);
      queue_point(24'hAAAAAA, 24'h555555, 24'hCCCCCC);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      rsp_chan.ready = 1'b0;
      cfg_damping = DAMPING_RESET;
      cfg_step = STEP_RESET;
      cfg_method = METHOD_RK4;
      fail_count = 0;
      no_idle = 1'b0;
      req_taken = 1'b0;
      send_gap = 0;
      stall_left = 0;
      hold_request = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: directed points with both integrators.
      queue_directed();
      drain();
      csr_write(REG_METHOD, METHOD_EULER);
      queue_directed();
      drain();

      // Long receiver hold-off so the pipeline fills and stalls its input.
      csr_write(REG_METHOD, METHOD_RK4);
      hold_request = 400;
      queue_random(150);
      drain();

      // Coefficient extremes, including values above one that get clamped.
      csr_write(REG_DAMPING, 0);
      csr_write(REG_STEP, COEF_ONE);
      queue_directed();
      queue_random(120);
      drain();
      csr_write(REG_DAMPING, 32'h7FFFF);
      csr_write(REG_STEP, 32'h7FFFF);
      csr_write(REG_METHOD, METHOD_EULER);
      queue_random(120);
      drain();

      // Zero step leaves every point where it was.
      csr_write(REG_STEP, 0);
      csr_write_unmapped(32'hFFFFFFFF);
      queue_directed();
      queue_random(60);
      drain();

      csr_write(REG_DAMPING, COEF_ONE);
      csr_write(REG_STEP, 1);
      csr_write(REG_METHOD, METHOD_RK4);
      no_idle = 1'b1;
      queue_random(120);
      drain();
      no_idle = 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(REG_DAMPING, $urandom_range(0, 262144));
         csr_write(REG_STEP, $urandom_range(1, 262144));
         csr_write(REG_METHOD, method_type'(ph % 2));
         queue_random(75);
         drain();
      end

      if (expected_points.size() != 0) begin
         fail_count = fail_count + 1;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
